FILE: hw/rtl/addressed_frame_receiver_defines.svh
// Assertion macros used by the checker file of the frame receiver.
`ifndef ADDRESSED_FRAME_RECEIVER_DEFINES_SVH
`define ADDRESSED_FRAME_RECEIVER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define AFR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define AFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

FILE: hw/rtl/afr_pkg.sv
`timescale 1ns / 1ps

package afr_pkg;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] REG_NODE_ADDRESS      = 2'd0;
    localparam logic [1:0] REG_BROADCAST_ADDRESS = 2'd1;
    localparam logic [1:0] REG_START_BYTE        = 2'd2;
    localparam logic [1:0] REG_TIMEOUT_TICKS     = 2'd3;

    localparam logic [15:0] HDR_ADDRESS  = 16'd1;
    localparam logic [15:0] HDR_FUNCTION = 16'd2;
    localparam logic [15:0] HDR_LEN_LOW  = 16'd3;
    localparam logic [15:0] HDR_LEN_HIGH = 16'd4;

    localparam logic [7:0] ECHO_FUNCTION    = 8'hF1;
    localparam logic [7:0] ECHO_SUBFUNCTION = 8'hD2;

    typedef struct packed {
        logic [7:0] node_address;
        logic [7:0] broadcast_address;
        logic [7:0] start_byte;
        logic [3:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  reply_second;
        logic [7:0]  reply_first;
        logic [7:0]  reply_function;
        logic [15:0] payload_length;
        logic [7:0]  subfunction;
        logic [7:0]  function_code;
    } result_t;

endpackage

FILE: hw/rtl/afr_cfg_regs.sv
`timescale 1ns / 1ps

module afr_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    output afr_pkg::cfg_t cfg
);
    import afr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_NODE_ADDRESS:      cfg_next.node_address      = cfg_data;
                REG_BROADCAST_ADDRESS: cfg_next.broadcast_address = cfg_data;
                REG_START_BYTE:        cfg_next.start_byte        = cfg_data;
                REG_TIMEOUT_TICKS:     cfg_next.timeout_ticks     = cfg_data[3:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node_address      <= 8'd1;
            cfg_reg.broadcast_address <= 8'd255;
            cfg_reg.start_byte        <= 8'h3A;
            cfg_reg.timeout_ticks     <= 4'd4;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/afr_frame_fsm.sv
`timescale 1ns / 1ps

module afr_frame_fsm (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             item_op,
    input  logic [7:0]       item_byte,
    input  afr_pkg::cfg_t    cfg,
    output logic             res_valid,
    output logic             res_reply,
    output afr_pkg::result_t res
);
    import afr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] idx_reg, idx_next;
    logic [7:0]  func_reg, func_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  first_reg, first_next;
    logic        off_reg, off_next;
    logic [3:0]  tick_reg, tick_next;
    logic [3:0]  tick_inc;
    logic        in_payload;
    logic        echo;

    assign tick_inc   = tick_reg + 4'd1;
    assign in_payload = idx_reg < len_reg;

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        func_next  = func_reg;
        len_next   = len_reg;
        addr_next  = addr_reg;
        first_next = first_reg;
        off_next   = off_reg;
        tick_next  = tick_reg;
        if (step) begin
            if (item_op == OP_TICK) begin
                if (off_reg) begin
                    if (tick_inc == cfg.timeout_ticks) begin
                        off_next   = 1'b0;
                        tick_next  = 4'd0;
                        phase_next = PH_HUNT;
                        idx_next   = 16'd0;
                    end else begin
                        tick_next = tick_inc;
                    end
                end
            end else if (!off_reg) begin
                case (phase_reg)
                    PH_PAYLOAD: begin
                        if (in_payload) begin
                            if (idx_reg == 16'd0) begin
                                first_next = item_byte;
                            end
                            idx_next = idx_reg + 16'd1;
                        end else begin
                            phase_next = PH_HUNT;
                            idx_next   = 16'd0;
                        end
                    end
                    PH_HEADER: begin
                        idx_next = idx_reg + 16'd1;
                        case (idx_reg)
                            HDR_ADDRESS:  addr_next = item_byte;
                            HDR_FUNCTION: func_next = item_byte;
                            HDR_LEN_LOW:  len_next  = {len_reg[15:8], item_byte};
                            HDR_LEN_HIGH: len_next  = {item_byte, len_reg[7:0]};
                            default:      len_next  = len_reg;
                        endcase
                        if (idx_reg == HDR_LEN_HIGH) begin
                            idx_next = 16'd0;
                            if (addr_reg == cfg.node_address ||
                                addr_reg == cfg.broadcast_address) begin
                                phase_next = PH_PAYLOAD;
                            end else begin
                                phase_next = PH_HUNT;
                                off_next   = 1'b1;
                                tick_next  = 4'd0;
                            end
                        end
                    end
                    default: begin
                        if (item_byte == cfg.start_byte) begin
                            phase_next = PH_HEADER;
                            idx_next   = HDR_ADDRESS;
                        end else begin
                            phase_next = PH_HUNT;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        res_valid = step && (item_op == OP_BYTE) && !off_reg &&
                    (phase_reg == PH_PAYLOAD) && !in_payload;
        echo      = (func_reg == ECHO_FUNCTION) && (first_reg == ECHO_SUBFUNCTION);
        res_reply = echo;
        res.function_code  = func_reg;
        res.subfunction    = first_reg;
        res.payload_length = len_reg;
        res.reply_function = echo ? ECHO_FUNCTION : 8'd0;
        res.reply_first    = echo ? ECHO_SUBFUNCTION : 8'd0;
        res.reply_second   = echo ? cfg.node_address : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            idx_reg   <= 16'd0;
            func_reg  <= 8'd0;
            len_reg   <= 16'd0;
            addr_reg  <= 8'd0;
            first_reg <= 8'd0;
            off_reg   <= 1'b0;
            tick_reg  <= 4'd0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            func_reg  <= func_next;
            len_reg   <= len_next;
            addr_reg  <= addr_next;
            first_reg <= first_next;
            off_reg   <= off_next;
            tick_reg  <= tick_next;
        end
    end

endmodule

FILE: hw/rtl/addressed_frame_receiver.sv
`timescale 1ns / 1ps

// Channel   | Direction | Payload
// ----------+-----------+------------------------------------------------------
// s_axis    | in        | tdata: data_byte; tuser: operation
// m_axis    | out       | tdata: function_code .. reply_second; tuser: reply_valid
// cfg       | in        | cfg_index selects the register, cfg_data is written
//
// An accepted item is held in the input register, then updates the frame
// state and, when it completes a frame, loads the result register.
// One item per cycle is sustained while the result side takes what it is given.
// Reset is synchronous on aresetn low and clears the valid flags of both registers
// and the frame state.
// A stalled result holds the result register; the input register then fills and
// s_tready drops until the result is taken.

module addressed_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] function_code, [15:8] subfunction, [31:16] payload_length,
    // [39:32] reply_function, [47:40] reply_first, [55:48] reply_second
    output logic [55:0] m_tdata,
    output logic        m_tuser,   // [0] reply_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import afr_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic [55:0] out_data_reg;
    logic       out_user_reg;
    logic       advance;
    logic       in_take;
    logic       res_valid;
    logic       res_reply;
    result_t    res;
    cfg_t       cfg;

    assign cfg_ready = 1'b1;

    afr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    afr_frame_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item_op   (in_op_reg),
        .item_byte (in_byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_reply (res_reply),
        .res       (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance && res_valid) begin
            out_data_reg <= res;
            out_user_reg <= res_reply;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: hw/rtl/afr_checker.sv
`timescale 1ns / 1ps
`include "addressed_frame_receiver_defines.svh"

module afr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);
    import afr_pkg::*;

    `AFR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `AFR_ASSERT_SAME(a_reply_fields, m_tvalid && m_tuser, m_tdata[39:32] == ECHO_FUNCTION && m_tdata[47:40] == ECHO_SUBFUNCTION)
    `AFR_ASSERT_SAME(a_reply_source, m_tvalid && m_tuser, m_tdata[7:0] == ECHO_FUNCTION && m_tdata[15:8] == ECHO_SUBFUNCTION)
    `AFR_ASSERT_SAME(a_no_reply_zero, m_tvalid && !m_tuser, m_tdata[55:32] == 24'd0)

endmodule

bind addressed_frame_receiver afr_checker u_afr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import afr_pkg::*;

    localparam logic [15:0] HEADER_LEN = 16'd5;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_SHOWN = 10;
    localparam int RANDOM_PHASES = 5;
    localparam int RANDOM_ITEMS = 650;

    typedef struct {
        result_t fields;
        logic    reply_valid;
    } frame_report_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic        s_tuser = OP_BYTE; // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] function_code, [15:8] subfunction, [31:16] payload_length,
    // [39:32] reply_function, [47:40] reply_first, [55:48] reply_second
    logic [55:0] m_tdata;
    logic        m_tuser;           // [0] reply_valid
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_NODE_ADDRESS;
    logic [7:0]  cfg_data = 8'h00;

    addressed_frame_receiver u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Expected frame state and register copy.
    cfg_t        cur_cfg = {8'd1, 8'd255, 8'h3A, 4'd4};
    phase_t      rx_phase = PH_HUNT;
    logic [15:0] rx_index = 16'd0;
    logic [7:0]  held_function = 8'h00;
    logic [15:0] held_length = 16'd0;
    logic [7:0]  held_address = 8'h00;
    logic [7:0]  first_payload = 8'h00;
    logic        rx_off = 1'b0;
    logic [3:0]  tick_count = 4'd0;

    frame_report_t due_reports[$];
    int  mismatch_count = 0;
    int  useful_items = 0;
    int  hold_request = 0;
    bit  tx_fast = 1'b0;
    bit  tick_noise = 1'b0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic predict_item(input logic op, input logic [7:0] value,
                                output frame_report_t rep, output bit made,
                                output bit skipped);
        bit echo;
        bit in_header;
        made = 1'b0;
        skipped = 1'b0;
        rep.fields = '0;
        rep.reply_valid = 1'b0;
        if (op == OP_TICK) begin
            if (rx_off) begin
                tick_count = tick_count + 4'd1;
                if (tick_count == cur_cfg.timeout_ticks) begin
                    rx_off = 1'b0;
                    tick_count = 4'd0;
                    rx_phase = PH_HUNT;
                    rx_index = 16'd0;
                end
            end else begin
                skipped = 1'b1;
            end
        end else if (rx_off) begin
            skipped = 1'b1;
        end else if (rx_phase == PH_PAYLOAD) begin
            if (rx_index < held_length) begin
                if (rx_index == 16'd0) begin
                    first_payload = value;
                end
                rx_index = rx_index + 16'd1;
            end else begin
                rx_phase = PH_HUNT;
                rx_index = 16'd0;
                echo = (held_function == ECHO_FUNCTION) && (first_payload == ECHO_SUBFUNCTION);
                rep.fields.function_code = held_function;
                rep.fields.subfunction = first_payload;
                rep.fields.payload_length = held_length;
                rep.fields.reply_function = echo ? ECHO_FUNCTION : 8'h00;
                rep.fields.reply_first = echo ? ECHO_SUBFUNCTION : 8'h00;
                rep.fields.reply_second = echo ? cur_cfg.node_address : 8'h00;
                rep.reply_valid = echo;
                made = 1'b1;
            end
        end else begin
            in_header = 1'b1;
            if (rx_phase != PH_HEADER) begin
                rx_phase = PH_HUNT;
                if (value == cur_cfg.start_byte) begin
                    rx_phase = PH_HEADER;
                    rx_index = 16'd0;
                end else begin
                    in_header = 1'b0;
                end
            end
            if (in_header) begin
                case (rx_index)
                    HDR_ADDRESS:  held_address = value;
                    HDR_FUNCTION: held_function = value;
                    HDR_LEN_LOW:  held_length[7:0] = value;
                    HDR_LEN_HIGH: held_length[15:8] = value;
                    default: ;
                endcase
                rx_index = rx_index + 16'd1;
                if (rx_index == HEADER_LEN) begin
                    rx_index = 16'd0;
                    if (held_address == cur_cfg.node_address
                            || held_address == cur_cfg.broadcast_address) begin
                        rx_phase = PH_PAYLOAD;
                    end else begin
                        rx_phase = PH_HUNT;
                        rx_off = 1'b1;
                        tick_count = 4'd0;
                    end
                end
            end
        end
    endtask

    task automatic send_item(input logic op, input logic [7:0] value);
        int gap;
        frame_report_t rep;
        bit made;
        bit skipped;
        gap = tx_fast ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= value;
        do @(posedge aclk); while (!s_tready);
        predict_item(op, value, rep, made, skipped);
        if (made) begin
            due_reports.push_back(rep);
        end
        if (!skipped) begin
            useful_items++;
        end
    endtask

    task automatic send_byte(input logic [7:0] value);
        if (tick_noise && $urandom_range(0, 19) == 0) begin
            send_item(OP_TICK, 8'($urandom));
        end
        send_item(OP_BYTE, value);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom));
    endtask

    // Header, then payload and the completing byte unless the address was foreign.
    task automatic send_frame(input logic [7:0] address, input logic [7:0] func,
                              input logic [15:0] length, input logic [7:0] first,
                              input logic [7:0] closing);
        send_byte(cur_cfg.start_byte);
        send_byte(address);
        send_byte(func);
        send_byte(length[7:0]);
        send_byte(length[15:8]);
        if (!rx_off) begin
            for (int i = 0; i < int'(length); i++) begin
                send_byte(i == 0 ? first : 8'($urandom));
            end
            send_byte(closing);
        end
    endtask

    task automatic recover_receiver();
        while (rx_off) begin
            send_tick();
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (due_reports.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_config(input cfg_t c);
        wait_idle();
        write_register(REG_NODE_ADDRESS, c.node_address);
        write_register(REG_BROADCAST_ADDRESS, c.broadcast_address);
        write_register(REG_START_BYTE, c.start_byte);
        write_register(REG_TIMEOUT_TICKS, {4'h0, c.timeout_ticks});
        cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    function automatic logic [7:0] foreign_address();
        logic [7:0] a;
        a = 8'($urandom);
        while (a == cur_cfg.node_address || a == cur_cfg.broadcast_address) begin
            a = a + 8'd1;
        end
        return a;
    endfunction

    task automatic send_random_frame();
        logic [7:0]  address;
        logic [7:0]  func;
        logic [15:0] length;
        logic [7:0]  first;
        logic [7:0]  closing;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            address = cur_cfg.node_address;
        end else if (pick < 7) begin
            address = cur_cfg.broadcast_address;
        end else if (pick < 9) begin
            address = foreign_address();
        end else begin
            address = 8'($urandom);
        end
        func = ($urandom_range(0, 3) == 0) ? ECHO_FUNCTION : 8'($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            length = 16'($urandom_range(0, 3));
        end else if (pick < 18) begin
            length = 16'($urandom_range(4, 16));
        end else begin
            length = 16'($urandom_range(17, 300));
        end
        first = (func == ECHO_FUNCTION && $urandom_range(0, 1) == 0)
                ? ECHO_SUBFUNCTION : 8'($urandom);
        closing = ($urandom_range(0, 4) == 0) ? cur_cfg.start_byte : 8'($urandom);
        send_frame(address, func, length, first, closing);
    endtask

    task automatic check_report();
        result_t got;
        frame_report_t want;
        got = m_tdata;
        if (due_reports.size() == 0) begin
            if (mismatch_count < MAX_SHOWN) begin
                $display("Unexpected result: fc=%h sub=%h len=%h rv=%b rf=%h r1=%h r2=%h",
                         got.function_code, got.subfunction, got.payload_length, m_tuser,
                         got.reply_function, got.reply_first, got.reply_second);
            end
            mismatch_count++;
        end else begin
            want = due_reports.pop_front();
            if (got.function_code !== want.fields.function_code
                    || got.subfunction !== want.fields.subfunction
                    || got.payload_length !== want.fields.payload_length
                    || m_tuser !== want.reply_valid
                    || got.reply_function !== want.fields.reply_function
                    || got.reply_first !== want.fields.reply_first
                    || got.reply_second !== want.fields.reply_second) begin
                if (mismatch_count < MAX_SHOWN) begin
                    $display("Mismatch: expected fc=%h sub=%h len=%h rv=%b rf=%h r1=%h r2=%h",
                             want.fields.function_code, want.fields.subfunction,
                             want.fields.payload_length, want.reply_valid,
                             want.fields.reply_function, want.fields.reply_first,
                             want.fields.reply_second);
                    $display("          actual   fc=%h sub=%h len=%h rv=%b rf=%h r1=%h r2=%h",
                             got.function_code, got.subfunction, got.payload_length, m_tuser,
                             got.reply_function, got.reply_first, got.reply_second);
                end
                mismatch_count++;
            end
        end
    endtask

    initial begin
        int stall;
        bit rx_fast;
        rx_fast = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                rx_fast = !rx_fast;
            end
            stall = rx_fast ? 0 : $urandom_range(0, 13);
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_report();
        end
    end

    // Reset values: node 1, broadcast 0xFF, start 0x3A, four ticks off.
    task automatic test_reset_frames();
        send_tick();
        send_frame(8'h01, 8'h10, 16'h0000, 8'h00, 8'h55);
        send_frame(8'h01, ECHO_FUNCTION, 16'h0001, ECHO_SUBFUNCTION, 8'h3A);
        send_frame(8'hFF, ECHO_FUNCTION, 16'h0000, 8'h00, 8'h00);
        send_frame(8'h07, 8'h20, 16'hFFFF, 8'h00, 8'h00);
        send_byte(8'h3A);
        repeat (3) send_tick();
        send_byte(8'hFF);
        send_tick();
        send_frame(8'h01, 8'h80, 16'h0002, 8'h7E, 8'hFF);
    endtask

    task automatic test_config_extremes();
        set_config({8'h00, 8'hFF, 8'h00, 4'd15});
        send_frame(8'h00, ECHO_FUNCTION, 16'h0001, ECHO_SUBFUNCTION, 8'h00);
        send_frame(8'hFF, 8'h00, 16'h0003, 8'hFF, 8'h12);
        send_frame(8'h80, 8'h01, 16'h0000, 8'h00, 8'h00);
        recover_receiver();
        set_config({8'hFF, 8'h00, 8'hFF, 4'd1});
        send_frame(8'hFF, ECHO_FUNCTION, 16'h0002, ECHO_SUBFUNCTION, 8'hFF);
        send_frame(8'h00, 8'hC3, 16'h0001, 8'h3C, 8'h00);
        send_frame(8'h01, 8'h02, 16'h0000, 8'h00, 8'h00);
        recover_receiver();
        // A zero timeout only releases the receiver once the tick count wraps.
        set_config({8'h5A, 8'hA5, 8'h3A, 4'd0});
        send_frame(8'h11, 8'h22, 16'h0000, 8'h00, 8'h00);
        recover_receiver();
        send_frame(8'hA5, ECHO_FUNCTION, 16'h0001, ECHO_SUBFUNCTION, 8'h3A);
    endtask

    task automatic test_long_payload();
        set_config({8'h01, 8'hFF, 8'h3A, 4'd4});
        tx_fast = 1'b1;
        send_frame(8'h01, 8'h44, 16'h0100, 8'h99, 8'h01);
        send_frame(8'hFF, ECHO_FUNCTION, 16'h0110, ECHO_SUBFUNCTION, 8'h3A);
        tx_fast = 1'b0;
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_request = 300;
        tx_fast = 1'b1;
        repeat (25) begin
            send_frame(cur_cfg.node_address, 8'($urandom), 16'h0000, 8'h00, 8'($urandom));
        end
        tx_fast = 1'b0;
    endtask

    task automatic test_random_traffic();
        cfg_t c;
        int goal;
        int pick;
        tick_noise = 1'b1;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            c.node_address = 8'($urandom);
            c.broadcast_address = ($urandom_range(0, 3) == 0) ? c.node_address : 8'($urandom);
            c.start_byte = 8'($urandom);
            c.timeout_ticks = 4'($urandom_range(1, 15));
            set_config(c);
            goal = useful_items + RANDOM_ITEMS / RANDOM_PHASES;
            while (useful_items < goal) begin
                if ($urandom_range(0, 9) == 0) begin
                    tx_fast = !tx_fast;
                end
                if (rx_off) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_item(OP_BYTE, 8'($urandom));
                    end else begin
                        send_tick();
                    end
                end else begin
                    pick = $urandom_range(0, 19);
                    if (pick < 2) begin
                        repeat ($urandom_range(1, 3)) send_item(OP_BYTE, 8'($urandom));
                    end else if (pick == 2) begin
                        send_tick();
                    end else begin
                        send_random_frame();
                    end
                end
            end
            tx_fast = 1'b0;
        end
        tick_noise = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_frames();
        test_config_extremes();
        test_long_payload();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
